// ===== rtl/core/fisr_pkg.sv =====
// Shared constants, operand class type and leading-zero counters for the
// reciprocal square root pipeline. No dependencies.
package fisr_pkg;

  localparam logic [31:0] MAGIC     = 32'h5f3759df;
  localparam logic [31:0] SIGN_BIT  = 32'h80000000;
  localparam logic [31:0] HALF      = 32'h3f000000;
  localparam logic [31:0] THREE_HLF = 32'h3fc00000;
  localparam logic [31:0] CANON_NAN = 32'h7fc00000;
  localparam logic [31:0] POS_INF   = 32'h7f800000;
  localparam int unsigned MUL_DEPTH = 3;
  localparam int unsigned ADD_DEPTH = 4;
  localparam int unsigned PIPE_DEPTH = 4 * MUL_DEPTH + ADD_DEPTH;

  typedef struct packed {
    logic nan;
    logic inf;
    logic zero;
    logic sign;
  } cls_t;

  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  function automatic logic [4:0] lzc28(input logic [27:0] v);
    logic [4:0] n;
    n = 5'd28;
    for (int i = 0; i < 28; i++) begin
      if (v[i]) n = 5'(27 - i);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/fisr_fmul.sv =====
// Three-stage single-precision multiplier, round to nearest-even.
// Depends on fisr_pkg.
module fisr_fmul (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] z
);

  // stage A: unpack and multiply
  logic [7:0]  ea_raw, eb_raw, ea_eff, eb_eff;
  logic [23:0] ma, mb;
  fisr_pkg::cls_t cls_a;
  logic        a_nan, a_inf, a_zero, b_nan, b_inf, b_zero;

  logic [47:0] p1;
  logic [9:0]  esum1;
  fisr_pkg::cls_t cls1;

  always_comb begin
    ea_raw = a[30:23];
    eb_raw = b[30:23];
    ea_eff = (ea_raw == 8'd0) ? 8'd1 : ea_raw;
    eb_eff = (eb_raw == 8'd0) ? 8'd1 : eb_raw;
    ma = {|ea_raw, a[22:0]};
    mb = {|eb_raw, b[22:0]};
    a_nan  = (ea_raw == 8'hff) && (|a[22:0]);
    a_inf  = (ea_raw == 8'hff) && !(|a[22:0]);
    a_zero = (ea_raw == 8'd0) && !(|a[22:0]);
    b_nan  = (eb_raw == 8'hff) && (|b[22:0]);
    b_inf  = (eb_raw == 8'hff) && !(|b[22:0]);
    b_zero = (eb_raw == 8'd0) && !(|b[22:0]);
    cls_a.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
    cls_a.inf  = a_inf || b_inf;
    cls_a.zero = a_zero || b_zero;
    cls_a.sign = a[31] ^ b[31];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1    <= ma * mb;
      esum1 <= {2'b00, ea_eff} + {2'b00, eb_eff};
      cls1  <= cls_a;
    end
  end

  // stage B: leading zeros and shift amount
  logic [5:0]         lz;
  logic signed [10:0] er_b, sh_b;

  logic [47:0]        p2;
  logic signed [10:0] er2, sh2;
  fisr_pkg::cls_t     cls2;

  always_comb begin
    lz   = fisr_pkg::lzc48(p1);
    er_b = $signed({1'b0, esum1}) - 11'sd126 - $signed({5'b00000, lz});
    sh_b = (er_b >= 11'sd1) ? $signed({5'b00000, lz})
                            : (er_b + $signed({5'b00000, lz}) - 11'sd1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2   <= p1;
      er2  <= er_b;
      sh2  <= sh_b;
      cls2 <= cls1;
    end
  end

  // stage C: normalise, round, pack
  logic [47:0]        q;
  logic               st, inc;
  logic signed [10:0] rs;
  logic [7:0]         expf;
  logic [30:0]        word;
  logic [31:0]        z_next;

  always_comb begin
    rs = -sh2;
    st = 1'b0;
    if (sh2 >= 11'sd0) begin
      q = p2 << sh2[5:0];
    end else if (rs >= 11'sd48) begin
      q  = 48'd0;
      st = |p2;
    end else begin
      q  = p2 >> rs[5:0];
      st = |(p2 & ((48'h1 << rs[5:0]) - 48'h1));
    end
    st   = st | (|q[22:0]);
    inc  = q[23] & (st | q[24]);
    expf = (er2 >= 11'sd1) ? er2[7:0] : 8'd0;
    word = {expf, q[46:24]} + {30'd0, inc};
    if (cls2.nan) begin
      z_next = fisr_pkg::CANON_NAN;
    end else if (cls2.inf || (er2 >= 11'sd255)) begin
      z_next = {cls2.sign, fisr_pkg::POS_INF[30:0]};
    end else if (cls2.zero) begin
      z_next = {cls2.sign, 31'd0};
    end else begin
      z_next = {cls2.sign, word};
    end
  end

  always_ff @(posedge clk) begin
    if (en) z <= z_next;
  end

endmodule

// ===== rtl/core/fisr_fadd.sv =====
// Four-stage single-precision adder, round to nearest-even.
// Depends on fisr_pkg.
module fisr_fadd (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] z
);

  // stage A: unpack and order by magnitude
  logic [31:0] bg, sm;
  logic        a_nan, a_inf, b_nan, b_inf;
  fisr_pkg::cls_t cls_a;
  logic [7:0]  ebg, esm;

  logic [23:0] mbg1, msm1;
  logic [7:0]  ebg1, d1;
  logic        sub1;
  fisr_pkg::cls_t cls1;

  always_comb begin
    if (b[30:0] > a[30:0]) begin
      bg = b;
      sm = a;
    end else begin
      bg = a;
      sm = b;
    end
    a_nan = (a[30:23] == 8'hff) && (|a[22:0]);
    a_inf = (a[30:23] == 8'hff) && !(|a[22:0]);
    b_nan = (b[30:23] == 8'hff) && (|b[22:0]);
    b_inf = (b[30:23] == 8'hff) && !(|b[22:0]);
    cls_a.nan  = a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]));
    cls_a.inf  = a_inf || b_inf;
    cls_a.zero = 1'b0;
    cls_a.sign = bg[31];
    ebg = (bg[30:23] == 8'd0) ? 8'd1 : bg[30:23];
    esm = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mbg1 <= {|bg[30:23], bg[22:0]};
      msm1 <= {|sm[30:23], sm[22:0]};
      ebg1 <= ebg;
      d1   <= ebg - esm;
      sub1 <= a[31] ^ b[31];
      cls1 <= cls_a;
    end
  end

  // stage B: align and add
  logic [26:0] ext, al;
  logic        ast;
  logic [27:0] sum_b;

  logic [27:0] sum2;
  logic [7:0]  ebg2;
  logic        sub2;
  fisr_pkg::cls_t cls2;

  always_comb begin
    ext = {msm1, 3'b000};
    if (d1 >= 8'd27) begin
      al  = 27'd0;
      ast = |msm1;
    end else begin
      al  = ext >> d1[4:0];
      ast = |(ext & ((27'h1 << d1[4:0]) - 27'h1));
    end
    al[0] = al[0] | ast;
    if (sub1) sum_b = {1'b0, mbg1, 3'b000} - {1'b0, al};
    else      sum_b = {1'b0, mbg1, 3'b000} + {1'b0, al};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum2 <= sum_b;
      ebg2 <= ebg1;
      sub2 <= sub1;
      cls2 <= cls1;
    end
  end

  // stage C: leading zeros
  logic [4:0]         lz;
  logic signed [10:0] er_c;

  logic [27:0]        sum3;
  logic signed [10:0] er3;
  logic [4:0]         sh3;
  logic               sub3;
  fisr_pkg::cls_t     cls3;

  always_comb begin
    lz   = fisr_pkg::lzc28(sum2);
    er_c = $signed({3'b000, ebg2}) + 11'sd1 - $signed({6'd0, lz});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum3 <= sum2;
      er3  <= er_c;
      sh3  <= (er_c >= 11'sd1) ? lz : ebg2[4:0];
      sub3 <= sub2;
      cls3 <= cls2;
    end
  end

  // stage D: normalise, round, pack
  logic [27:0] q;
  logic        inc;
  logic [7:0]  expf;
  logic [30:0] word;
  logic [31:0] z_next;

  always_comb begin
    q    = sum3 << sh3;
    inc  = q[3] & ((|q[2:0]) | q[4]);
    expf = (er3 >= 11'sd1) ? er3[7:0] : 8'd0;
    word = {expf, q[26:4]} + {30'd0, inc};
    if (cls3.nan) begin
      z_next = fisr_pkg::CANON_NAN;
    end else if (cls3.inf || (er3 >= 11'sd255)) begin
      z_next = {cls3.sign, fisr_pkg::POS_INF[30:0]};
    end else if (sum3 == 28'd0) begin
      z_next = {cls3.sign & !sub3, 31'd0};
    end else begin
      z_next = {cls3.sign, word};
    end
  end

  always_ff @(posedge clk) begin
    if (en) z <= z_next;
  end

endmodule

// ===== rtl/core/fast_inverse_square_root_unit.sv =====
// Top level of the reciprocal square root pipeline: first guess, then
// h, h*y, t, 1.5-t and the final product. Uses fisr_pkg, fisr_fmul, fisr_fadd.
//
//   channel   ports                          width
//   request   x_valid  x_stall  x_bits        32
//   result    r_valid  r_stall  rsqrt_bits    32
//
// Four 3-stage multipliers and a 4-stage adder in series, taking one request per
// cycle while no stalled result holds the pipeline.
// Reset clears the valid bits only.
// A stalled result freezes the whole pipeline; x_stall is high exactly then.
module fast_inverse_square_root_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        x_valid,
  output logic        x_stall,
  input  logic [31:0] x_bits,
  output logic        r_valid,
  input  logic        r_stall,
  output logic [31:0] rsqrt_bits
);

  localparam int unsigned YT = 2 * fisr_pkg::MUL_DEPTH + fisr_pkg::ADD_DEPTH;

  logic en;
  logic [fisr_pkg::PIPE_DEPTH-1:0] vld;
  logic [31:0] y0;
  logic [31:0] y_dly [0:YT+fisr_pkg::MUL_DEPTH-1];
  logic [31:0] h, hy, t, d;

  assign en      = !(vld[fisr_pkg::PIPE_DEPTH-1] && r_stall);
  assign x_stall = !en;
  assign r_valid = vld[fisr_pkg::PIPE_DEPTH-1];
  assign y0 = fisr_pkg::MAGIC - ((x_bits >> 1) | (x_bits & fisr_pkg::SIGN_BIT));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[fisr_pkg::PIPE_DEPTH-2:0], x_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_dly[0] <= y0;
      for (int i = 1; i < YT + fisr_pkg::MUL_DEPTH; i++) y_dly[i] <= y_dly[i-1];
    end
  end

  fisr_fmul u_half (
    .clk(clk), .en(en), .a(x_bits), .b(fisr_pkg::HALF), .z(h)
  );

  fisr_fmul u_hy (
    .clk(clk), .en(en), .a(h), .b(y_dly[fisr_pkg::MUL_DEPTH-1]), .z(hy)
  );

  fisr_fmul u_t (
    .clk(clk), .en(en), .a(hy), .b(y_dly[2*fisr_pkg::MUL_DEPTH-1]), .z(t)
  );

  fisr_fadd u_d (
    .clk(clk), .en(en), .a(fisr_pkg::THREE_HLF), .b({~t[31], t[30:0]}), .z(d)
  );

  fisr_fmul u_r (
    .clk(clk), .en(en), .a(d), .b(y_dly[YT+fisr_pkg::MUL_DEPTH-1]), .z(rsqrt_bits)
  );

endmodule

// ===== rtl/core/fisr_checker.sv =====
// Port-level checks for fast_inverse_square_root_unit, bound to the top.
// Depends on fisr_pkg only.
module fisr_checker (
  input logic        clk,
  input logic        rst,
  input logic        x_valid,
  input logic        x_stall,
  input logic [31:0] x_bits,
  input logic        r_valid,
  input logic        r_stall,
  input logic [31:0] rsqrt_bits
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !r_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    r_valid && r_stall |=> r_valid && $stable(rsqrt_bits))
    else $error("stalled result changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    x_valid && x_stall |=> x_valid && $stable(x_bits))
    else $error("stalled request changed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    x_stall |-> r_valid && r_stall)
    else $error("request stalled without a blocked result");

  a_nan_canon: assert property (@(posedge clk) disable iff (rst)
    r_valid && rsqrt_bits[30:23] == 8'hff && rsqrt_bits[22:0] != 23'd0
      |-> rsqrt_bits == fisr_pkg::CANON_NAN)
    else $error("non-canonical NaN result");

endmodule

bind fast_inverse_square_root_unit fisr_checker u_fisr_checker (
  .clk(clk), .rst(rst), .x_valid(x_valid), .x_stall(x_stall), .x_bits(x_bits),
  .r_valid(r_valid), .r_stall(r_stall), .rsqrt_bits(rsqrt_bits)
);

// ===== bench/fast_inverse_square_root_unit_tb.sv =====
// Testbench for fast_inverse_square_root_unit: random and corner operands, with
// an integer model of single-precision multiply and add (round to nearest even).
// Depends on fisr_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module fast_inverse_square_root_unit_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        x_valid = 1'b0;
  logic        x_stall;
  logic [31:0] x_bits = '0;
  logic        r_valid;
  logic        r_stall = 1'b0;
  logic [31:0] rsqrt_bits;

  logic [31:0] operand_q[$];
  logic [31:0] rsqrt_expected_q[$];
  int          n_errors = 0;
  int          drv_cycle = 0;
  int          mon_cycle = 0;
  bit          feed_done = 1'b0;

  fast_inverse_square_root_unit i_dut (
    .clk(clk), .rst(rst),
    .x_valid(x_valid), .x_stall(x_stall), .x_bits(x_bits),
    .r_valid(r_valid), .r_stall(r_stall), .rsqrt_bits(rsqrt_bits)
  );

  always #5 clk = ~clk;

  function automatic bit is_nan(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] != 0;
  endfunction

  function automatic bit is_inf(logic [31:0] a);
    return a[30:23] == 8'hff && a[22:0] == 0;
  endfunction

  // value = mag * 2^ex, rounded to single precision
  function automatic logic [31:0] round_single(bit s, bit [319:0] mag, int ex);
    int         p, e_top, q, sh;
    bit [319:0] kept, rem, one;
    bit         half, sticky;
    one = 1;
    if (mag == 0) return {s, 31'd0};
    p = 0;
    for (int i = 0; i < 320; i++) if (mag[i]) p = i;
    e_top = p + ex;
    q = ((e_top < -126) ? -126 : e_top) - 23;
    sh = q - ex;
    half = 1'b0;
    sticky = 1'b0;
    if (sh >= 320) begin
      kept = 0;
      sticky = 1'b1;
    end else if (sh > 0) begin
      kept = mag >> sh;
      rem = mag - (kept << sh);
      half = rem[sh-1];
      sticky = (rem & ~(one << (sh - 1))) != 0;
    end else begin
      kept = mag << (-sh);
    end
    if (half && (sticky || kept[0])) kept = kept + 1;
    if (kept[24]) begin
      kept = kept >> 1;
      q++;
    end
    if (kept[23]) begin
      if (q + 150 >= 255) return {s, fisr_pkg::POS_INF[30:0]};
      return {s, 8'(q + 150), kept[22:0]};
    end
    return {s, 8'd0, kept[22:0]};
  endfunction

  function automatic void split_single(logic [31:0] a, output bit [23:0] m, output int e);
    if (a[30:23] == 0) begin
      m = {1'b0, a[22:0]};
      e = -149;
    end else begin
      m = {1'b1, a[22:0]};
      e = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] single_mul(logic [31:0] a, logic [31:0] b);
    bit [23:0]  ma, mb;
    int         ea, eb;
    bit         s;
    bit [319:0] prod;
    s = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return fisr_pkg::CANON_NAN;
      return {s, fisr_pkg::POS_INF[30:0]};
    end
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    prod = 320'(ma) * 320'(mb);
    return round_single(s, prod, ea + eb);
  endfunction

  function automatic logic [31:0] single_add(logic [31:0] a, logic [31:0] b);
    bit [23:0]  ma, mb;
    int         ea, eb, emin;
    bit [319:0] wa, wb;
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CANON_NAN;
    if (is_inf(a) && is_inf(b) && a[31] != b[31]) return fisr_pkg::CANON_NAN;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    split_single(a, ma, ea);
    split_single(b, mb, eb);
    emin = (ea < eb) ? ea : eb;
    wa = 320'(ma) << (ea - emin);
    wb = 320'(mb) << (eb - emin);
    if (a[31] == b[31]) return round_single(a[31], wa + wb, emin);
    if (wa == wb) return 32'd0;
    if (wa > wb) return round_single(a[31], wa - wb, emin);
    return round_single(b[31], wb - wa, emin);
  endfunction

  function automatic logic [31:0] rsqrt_predict(logic [31:0] x);
    logic [31:0] guess, h, hy, t, d, r;
    guess = fisr_pkg::MAGIC - ((x >> 1) | (x & fisr_pkg::SIGN_BIT));
    h  = single_mul(fisr_pkg::HALF, x);
    hy = single_mul(h, guess);
    t  = single_mul(hy, guess);
    d  = single_add(fisr_pkg::THREE_HLF, t ^ fisr_pkg::SIGN_BIT);
    r  = single_mul(guess, d);
    return is_nan(r) ? fisr_pkg::CANON_NAN : r;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      x_valid <= 1'b0;
    end else begin
      drv_cycle <= drv_cycle + 1;
      if (x_valid && !x_stall) rsqrt_expected_q.push_back(rsqrt_predict(x_bits));
      if (!x_valid || !x_stall) begin
        if (operand_q.size() > 0 &&
            ((drv_cycle > 1000 && drv_cycle < 1500) || $urandom_range(99) >= 17)) begin
          x_bits  <= operand_q.pop_front();
          x_valid <= 1'b1;
        end else begin
          x_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      r_stall <= 1'b0;
    end else begin
      mon_cycle <= mon_cycle + 1;
      if (r_valid && !r_stall) begin
        if (rsqrt_expected_q.size() == 0) begin
          $error("unexpected result rsqrt_bits=%h", rsqrt_bits);
          n_errors++;
        end else begin
          logic [31:0] want;
          want = rsqrt_expected_q.pop_front();
          if (rsqrt_bits !== want) begin
            $error("rsqrt_bits mismatch: expected %h actual %h", want, rsqrt_bits);
            n_errors++;
          end
        end
      end
      if (mon_cycle >= 300 && mon_cycle < 400) r_stall <= 1'b1;   // long hold-off
      else if (mon_cycle > 1000 && mon_cycle < 1500) r_stall <= 1'b0;
      else r_stall <= ($urandom_range(99) < 17);
    end
  end

  initial begin
    logic [31:0] corner[$];
    corner = '{32'h00000000, 32'h80000000, 32'h7f800000, 32'hff800000,
               32'h7fc00000, 32'h7f800001, 32'hffffffff, 32'h00000001,
               32'h007fffff, 32'h00800000, 32'h3f800000, 32'h40800000,
               32'h7f7fffff, 32'hbf800000, 32'h3e800000, 32'h00000002,
               32'h80000001, 32'h7fffffff, 32'hbe6eb3be, 32'h5f3759df,
               32'hc0000000, 32'h3eaaaaab};
    foreach (corner[i]) operand_q.push_back(corner[i]);
    for (int i = 0; i < 1800; i++) begin
      if ($urandom_range(99) < 60)
        operand_q.push_back({1'b0, 8'($urandom_range(1, 254)), 23'($urandom)});
      else if ($urandom_range(99) < 20)
        operand_q.push_back({1'b0, 8'd0, 23'($urandom)});
      else
        operand_q.push_back($urandom);
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait (operand_q.size() == 0 && !x_valid && rsqrt_expected_q.size() == 0);
    repeat (40) @(posedge clk);
    if (n_errors == 0 && rsqrt_expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/fisr_pkg.sv
rtl/core/fisr_fmul.sv
rtl/core/fisr_fadd.sv
rtl/core/fast_inverse_square_root_unit.sv
rtl/core/fisr_checker.sv
bench/fast_inverse_square_root_unit_tb.sv
